FILE: rtl/calendar_clock_advance_unit_assert.svh
// Assertion macros for the calendar clock advance unit.
`ifndef CALENDAR_CLOCK_ADVANCE_UNIT_ASSERT_SVH
`define CALENDAR_CLOCK_ADVANCE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cca_pkg.sv
// Types, trigger codes and date helper functions for the calendar clock.
`timescale 1ns / 1ps

package cca_pkg;

	localparam int SEC_W   = 6;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int WDAY_W  = 3;
	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 16;
	localparam int TRIG_W  = 3;

	typedef logic [TRIG_W-1:0] cca_trig_t;

	localparam cca_trig_t TRIG_FIVE_SEC   = 3'd0;
	localparam cca_trig_t TRIG_TEN_MIN    = 3'd1;
	localparam cca_trig_t TRIG_THIRTY_MIN = 3'd2;
	localparam cca_trig_t TRIG_HOUR       = 3'd3;
	localparam cca_trig_t TRIG_DAY        = 3'd4;
	localparam cca_trig_t TRIG_MONTH      = 3'd5;
	localparam cca_trig_t TRIG_LOADED     = 3'd6;

	// multiplicative inverse of 25 modulo 2^16, and the largest product of a multiple
	localparam logic [YEAR_W-1:0] INV25     = 16'h5C29;
	localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  weekday;
		logic [HOUR_W-1:0]  hour;
		logic [MIN_W-1:0]   minute;
		logic [SEC_W-1:0]   second;
	} cca_time_t;

	localparam int TIME_W  = $bits(cca_time_t);
	localparam int TDATA_W = ((TIME_W + 7) / 8) * 8;

	function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
			input logic leap);
		logic [DAY_W-1:0] n;
		case (month)
			4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
			4'd2:                    n = leap ? 5'd29 : 5'd28;
			default:                 n = 5'd31;
		endcase
		return n;
	endfunction

	// trigger for a minute count just reached by a second carry
	function automatic cca_trig_t minute_trig(input logic [MIN_W-1:0] m);
		cca_trig_t t;
		if (m == 6'd30 || m == 6'd60)
			t = TRIG_THIRTY_MIN;
		else if (m == 6'd10 || m == 6'd20 || m == 6'd40 || m == 6'd50)
			t = TRIG_TEN_MIN;
		else
			t = TRIG_FIVE_SEC;
		return t;
	endfunction

endpackage

FILE: rtl/cca_leap.sv
// Gregorian leap-year flag for a 16-bit year.
`timescale 1ns / 1ps

module cca_leap (
	input  logic [cca_pkg::YEAR_W-1:0] year,
	output logic                       leap
);

	logic [2*cca_pkg::YEAR_W-1:0] prod;
	logic                         div25;

	assign prod  = {{cca_pkg::YEAR_W{1'b0}}, year} *
		{{cca_pkg::YEAR_W{1'b0}}, cca_pkg::INV25};
	assign div25 = prod[cca_pkg::YEAR_W-1:0] <= cca_pkg::DIV25_MAX;
	assign leap  = (year[1:0] == 2'd0) && !(div25 && (year[3:0] != 4'd0));

endmodule

FILE: rtl/cca_step.sv
// Next-state logic: load with saturation, or one tick with the full date ripple.
`timescale 1ns / 1ps

module cca_step #(
	parameter int STEP_SECONDS = 5
) (
	input  cca_pkg::cca_time_t cur,
	input  logic               cur_leap,
	input  logic               op,
	input  cca_pkg::cca_time_t set,
	output cca_pkg::cca_time_t nxt,
	output cca_pkg::cca_trig_t trig
);

	logic [cca_pkg::SEC_W:0]     sec_sum;
	logic                        sec_wrap;
	logic [cca_pkg::MIN_W-1:0]   min_inc;
	logic                        min_wrap;
	logic [cca_pkg::HOUR_W-1:0]  hour_inc;
	logic                        hour_wrap;
	logic [cca_pkg::DAY_W:0]     day_a;
	logic                        day_wrap;
	logic                        month_wrap;
	logic [cca_pkg::DAY_W-1:0]   mdays;
	cca_pkg::cca_time_t          tick_t;
	cca_pkg::cca_time_t          load_t;
	cca_pkg::cca_trig_t          tick_trig;

	always_comb begin
		sec_sum   = {1'b0, cur.second} + (cca_pkg::SEC_W+1)'(STEP_SECONDS);
		sec_wrap  = sec_sum >= 7'd60;
		min_inc   = cur.minute + 6'd1;
		min_wrap  = sec_wrap && (min_inc >= 6'd60);
		hour_inc  = cur.hour + 5'd1;
		hour_wrap = min_wrap && (hour_inc >= 5'd24);
		mdays     = cca_pkg::month_days(cur.month, cur_leap);
		day_a     = {1'b0, cur.day} + {5'd0, hour_wrap};
		day_wrap  = day_a > {1'b0, mdays};
		month_wrap = day_wrap && (cur.month >= 4'd12);

		tick_t.second  = sec_wrap ? 6'd0 : sec_sum[cca_pkg::SEC_W-1:0];
		tick_t.minute  = min_wrap ? 6'd0 : (sec_wrap ? min_inc : cur.minute);
		tick_t.hour    = hour_wrap ? 5'd0 : (min_wrap ? hour_inc : cur.hour);
		if (hour_wrap)
			tick_t.weekday = (cur.weekday >= 3'd7) ? 3'd1 : cur.weekday + 3'd1;
		else
			tick_t.weekday = cur.weekday;
		tick_t.day     = day_wrap ? 5'd1 : day_a[cca_pkg::DAY_W-1:0];
		if (month_wrap)
			tick_t.month = 4'd1;
		else if (day_wrap)
			tick_t.month = cur.month + 4'd1;
		else
			tick_t.month = cur.month;
		tick_t.year    = month_wrap ? cur.year + 16'd1 : cur.year;

		if (day_wrap)
			tick_trig = cca_pkg::TRIG_MONTH;
		else if (hour_wrap)
			tick_trig = cca_pkg::TRIG_DAY;
		else if (min_wrap)
			tick_trig = cca_pkg::TRIG_HOUR;
		else if (sec_wrap)
			tick_trig = cca_pkg::minute_trig(min_inc);
		else
			tick_trig = cca_pkg::TRIG_FIVE_SEC;

		// saturate each loaded field to its range
		load_t.second  = (set.second > 6'd59) ? 6'd59 : set.second;
		load_t.minute  = (set.minute > 6'd59) ? 6'd59 : set.minute;
		load_t.hour    = (set.hour > 5'd23) ? 5'd23 : set.hour;
		load_t.weekday = (set.weekday == 3'd0) ? 3'd1 : set.weekday;
		load_t.day     = (set.day == 5'd0) ? 5'd1 : set.day;
		if (set.month == 4'd0)
			load_t.month = 4'd1;
		else if (set.month > 4'd12)
			load_t.month = 4'd12;
		else
			load_t.month = set.month;
		load_t.year    = set.year;

		nxt  = op ? load_t : tick_t;
		trig = op ? cca_pkg::TRIG_LOADED : tick_trig;
	end

endmodule

FILE: rtl/calendar_clock_advance_unit.sv
// Top level of the calendar clock advance unit.
// Path: a transaction passes the input register, then the result register, which is
// updated together with the clock state.
// Throughput: one transaction per cycle while m_tready holds, set by the combinational date ripple.
// Reset: pipeline empty, time 00:00:00, weekday 1, 1 January of year 0.
`timescale 1ns / 1ps

module calendar_clock_advance_unit #(
	parameter int STEP_SECONDS = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// set_second, set_minute, set_hour, set_weekday, set_day, set_month, set_year, zero fill
	input  logic [cca_pkg::TDATA_W-1:0] s_tdata,
	// op
	input  logic [0:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// now_second, now_minute, now_hour, now_weekday, now_day, now_month, now_year, zero fill
	output logic [cca_pkg::TDATA_W-1:0] m_tdata,
	// trigger
	output logic [cca_pkg::TRIG_W-1:0]  m_tuser
);

	logic               valid_s1;
	logic               op_s1;
	cca_pkg::cca_time_t set_s1;
	logic               valid_s2;
	cca_pkg::cca_trig_t trig_s2;
	cca_pkg::cca_time_t now_q;
	logic               leap_q;
	logic               adv;
	cca_pkg::cca_time_t nxt;
	cca_pkg::cca_trig_t nxt_trig;
	logic               nxt_leap;

	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1  <= s_tuser[0];
			set_s1 <= cca_pkg::cca_time_t'(s_tdata[cca_pkg::TIME_W-1:0]);
		end
	end

	cca_step #(
		.STEP_SECONDS(STEP_SECONDS)
	) u_step (
		.cur      (now_q),
		.cur_leap (leap_q),
		.op       (op_s1),
		.set      (set_s1),
		.nxt      (nxt),
		.trig     (nxt_trig)
	);

	cca_leap u_leap (
		.year (nxt.year),
		.leap (nxt_leap)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2       <= 1'b0;
			trig_s2        <= cca_pkg::TRIG_FIVE_SEC;
			now_q.second   <= '0;
			now_q.minute   <= '0;
			now_q.hour     <= '0;
			now_q.weekday  <= 3'd1;
			now_q.day      <= 5'd1;
			now_q.month    <= 4'd1;
			now_q.year     <= '0;
			leap_q         <= 1'b1;
		end else if (adv) begin
			valid_s2 <= 1'b1;
			trig_s2  <= nxt_trig;
			now_q    <= nxt;
			leap_q   <= nxt_leap;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = trig_s2;
	assign m_tdata  = {{(cca_pkg::TDATA_W-cca_pkg::TIME_W){1'b0}}, now_q};

endmodule

FILE: rtl/cca_checker.sv
// Port-level assertion checker for the calendar clock advance unit, with its bind.
`timescale 1ns / 1ps
`include "calendar_clock_advance_unit_assert.svh"

module cca_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [cca_pkg::TDATA_W-1:0] m_tdata,
	input logic [cca_pkg::TRIG_W-1:0]  m_tuser
);

	`CCA_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result transaction changed")
	`CCA_ASSERT_NOW(a_time_range, m_tvalid, m_tdata[5:0] <= 6'd59 && m_tdata[11:6] <= 6'd59 && m_tdata[16:12] <= 5'd23, "time of day out of range")
	`CCA_ASSERT_NOW(a_date_range, m_tvalid, m_tdata[19:17] != 3'd0 && m_tdata[24:20] != 5'd0 && m_tdata[28:25] != 4'd0 && m_tdata[28:25] <= 4'd12, "date field out of range")
	`CCA_ASSERT_NOW(a_trig_code, m_tvalid, m_tuser <= cca_pkg::TRIG_LOADED, "trigger code out of range")

endmodule

bind calendar_clock_advance_unit cca_checker u_cca_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/tb_calendar_clock_advance_unit.sv
// Self-checking testbench for the calendar clock advance unit: directed and random streams.
`timescale 1ns / 1ps

import cca_pkg::*;

localparam bit OP_TICK = 1'b0;
localparam bit OP_LOAD = 1'b1;

typedef struct {
	cca_trig_t trig;
	cca_time_t now;
} calendar_reading_t;

class calendar_tracker;
	int step;
	int sec, mins, hour, wday, day, month, year;
	calendar_reading_t due_q[$];
	int errors;

	function new(int step_sec);
		step   = step_sec;
		sec    = 0;
		mins   = 0;
		hour   = 0;
		wday   = 1;
		day    = 1;
		month  = 1;
		year   = 0;
		errors = 0;
	endfunction

	function bit leap_year(int y);
		return (y % 4 == 0) && !((y % 100 == 0) && (y % 400 != 0));
	endfunction

	function int month_length(int m, int y);
		case (m)
			4, 6, 9, 11: return 30;
			2:           return leap_year(y) ? 29 : 28;
			default:     return 31;
		endcase
	endfunction

	function int clamp(int v, int lo, int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function cca_trig_t advance_tick();
		cca_trig_t trig;
		int mdays;
		trig  = TRIG_FIVE_SEC;
		mdays = month_length(month, year);
		sec += step;
		if (sec >= 60) begin
			sec = 0;
			mins++;
			if (mins % 10 == 0)
				trig = TRIG_TEN_MIN;
			if (mins % 30 == 0)
				trig = TRIG_THIRTY_MIN;
		end
		if (mins >= 60) begin
			mins = 0;
			hour++;
			trig = TRIG_HOUR;
		end
		if (hour >= 24) begin
			hour = 0;
			day++;
			wday++;
			trig = TRIG_DAY;
		end
		if (wday > 7)
			wday = 1;
		if (day > mdays) begin
			day = 1;
			month++;
			trig = TRIG_MONTH;
		end
		if (month > 12) begin
			month = 1;
			year  = (year + 1) % 65536;
		end
		return trig;
	endfunction

	function void note_transaction(bit op, cca_time_t set);
		calendar_reading_t r;
		if (op == OP_LOAD) begin
			sec    = clamp(int'(set.second), 0, 59);
			mins   = clamp(int'(set.minute), 0, 59);
			hour   = clamp(int'(set.hour), 0, 23);
			wday   = clamp(int'(set.weekday), 1, 7);
			day    = clamp(int'(set.day), 1, 31);
			month  = clamp(int'(set.month), 1, 12);
			year   = int'(set.year);
			r.trig = TRIG_LOADED;
		end else begin
			r.trig = advance_tick();
		end
		r.now.second  = SEC_W'(sec);
		r.now.minute  = MIN_W'(mins);
		r.now.hour    = HOUR_W'(hour);
		r.now.weekday = WDAY_W'(wday);
		r.now.day     = DAY_W'(day);
		r.now.month   = MONTH_W'(month);
		r.now.year    = YEAR_W'(year);
		due_q.push_back(r);
	endfunction

	function int pending();
		return due_q.size();
	endfunction

	task report(string msg);
		if (errors < 50)
			$display("%0t ns: %s", $time, msg);
		errors++;
	endtask

	task compare(string what, int got, int want);
		if (got != want)
			report($sformatf("%s: got %0d, expected %0d", what, got, want));
	endtask

	task check_transaction(cca_trig_t trig, logic [TDATA_W-1:0] data);
		calendar_reading_t want;
		cca_time_t got;
		got = data[TIME_W-1:0];
		if (due_q.size() == 0) begin
			report($sformatf("unexpected result transaction, trigger %0d", trig));
			return;
		end
		want = due_q.pop_front();
		compare("trigger", int'(trig), int'(want.trig));
		compare("second", int'(got.second), int'(want.now.second));
		compare("minute", int'(got.minute), int'(want.now.minute));
		compare("hour", int'(got.hour), int'(want.now.hour));
		compare("weekday", int'(got.weekday), int'(want.now.weekday));
		compare("day", int'(got.day), int'(want.now.day));
		compare("month", int'(got.month), int'(want.now.month));
		compare("year", int'(got.year), int'(want.now.year));
	endtask
endclass

module tb_calendar_clock_advance_unit;

	localparam int TICK_SEC     = 5;
	localparam int STALL_PCT    = 38;
	localparam int ITEM_TARGET  = 1400;
	localparam int HANG_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata  = '0;
	logic [0:0]           s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	cca_trig_t            m_tuser;

	bit                   calm = 1'b0;
	int                   sent = 0;
	calendar_tracker      clock_model = new(TICK_SEC);

	calendar_clock_advance_unit #(
		.STEP_SECONDS(TICK_SEC)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			clock_model.check_transaction(m_tuser, m_tdata);
	end

	function automatic cca_time_t make_time(int h, int mi, int s, int wd, int d, int mo, int y);
		cca_time_t t;
		t.second  = SEC_W'(s);
		t.minute  = MIN_W'(mi);
		t.hour    = HOUR_W'(h);
		t.weekday = WDAY_W'(wd);
		t.day     = DAY_W'(d);
		t.month   = MONTH_W'(mo);
		t.year    = YEAR_W'(y);
		return t;
	endfunction

	task automatic send_item(input bit op, input cca_time_t t);
		while (!calm && $urandom_range(99) < STALL_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(t);
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		clock_model.note_transaction(op, t);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_noise(input bit op);
		logic [63:0] r;
		r = {$urandom, $urandom};
		send_item(op, r[TIME_W-1:0]);
	endtask

	task automatic load_then_tick(int h, int mi, int s, int wd, int d, int mo, int y);
		send_item(OP_LOAD, make_time(h, mi, s, wd, d, mo, y));
		send_noise(OP_TICK);
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (clock_model.pending() != 0)
			@(negedge clk);
	endtask

	initial begin : stimulus
		int  r, h, mi, s, wd, d, mo, y;
		bit  held;
		held = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_noise(OP_TICK);
		send_item(OP_LOAD, '1);
		send_noise(OP_TICK);
		send_item(OP_LOAD, '0);
		load_then_tick(23, 59, 55, 3, 29, 2, 0);
		load_then_tick(10, 0, 0, 5, 30, 2, 2023);
		load_then_tick(23, 59, 55, 2, 28, 2, 1900);
		load_then_tick(23, 59, 55, 2, 28, 2, 2000);
		load_then_tick(0, 9, 55, 1, 1, 1, 1);
		load_then_tick(0, 29, 55, 1, 1, 1, 1);
		load_then_tick(0, 59, 55, 1, 1, 1, 1);
		load_then_tick(23, 59, 55, 7, 10, 4, 2021);
		load_then_tick(23, 59, 55, 1, 30, 4, 2021);
		load_then_tick(23, 59, 55, 6, 31, 12, 2023);
		load_then_tick(12, 0, 58, 4, 15, 6, 2024);
		hold_until_drained();

		while (sent < ITEM_TARGET) begin
			calm = (sent >= 600 && sent < 800);
			if (!held && sent >= 1100) begin
				held = 1'b1;
				hold_until_drained();
			end
			r = $urandom_range(99);
			if (r < 70) begin
				mo = $urandom_range(12, 1);
				case ($urandom_range(5))
					0:       y = 0;
					1:       y = 1900;
					2:       y = 2000;
					3:       y = 65535;
					4:       y = $urandom_range(2099, 1999);
					default: y = $urandom_range(65535);
				endcase
				d = $urandom_range(1) ? clock_model.month_length(mo, y) : $urandom_range(31, 1);
				case ($urandom_range(3))
					0:       mi = 59;
					1:       mi = 10 * $urandom_range(5) + 9;
					default: mi = $urandom_range(59);
				endcase
				h  = $urandom_range(1) ? 23 : $urandom_range(23);
				s  = $urandom_range(59, 35);
				wd = $urandom_range(7, 1);
				send_item(OP_LOAD, make_time(h, mi, s, wd, d, mo, y));
				repeat ($urandom_range(24, 1)) send_noise(OP_TICK);
			end else if (r < 85) begin
				send_noise(OP_LOAD);
				repeat ($urandom_range(8)) send_noise(OP_TICK);
			end else begin
				repeat ($urandom_range(40, 1)) send_noise(OP_TICK);
			end
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		while (clock_model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (clock_model.errors == 0)
			$display("calendar_clock_advance_unit test passed");
		else
			$display("calendar_clock_advance_unit test failed");
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < HANG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("calendar_clock_advance_unit test failed");
		$finish;
	end

endmodule
